FILE: rtl/pbe_pkg.sv
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared constants, codes and controller/datapath command types for the
// sha-1 / hmac-sha1 password key derivation block.
// ----------------------------------------------------------------------------
package pbe_pkg;

  localparam int MsgDepth    = 64;
  localparam int MsgAw       = 6;
  localparam int SaltDepth   = 32;
  localparam int SaltAw      = 5;
  localparam int DigestBytes = 20;
  localparam int KeyWords    = 10;
  localparam int Rounds      = 80;

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;
  localparam logic [7:0] PadByte  = 8'h80;

  localparam logic [159:0] Sha1Iv = {32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                     32'h10325476, 32'hc3d2e1f0};

  typedef enum logic [1:0] {
    FN_MSG    = 2'd0,
    FN_SALT   = 2'd1,
    FN_DERIVE = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic {
    CFG_MSG_LEN  = 1'b0,
    CFG_SALT_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_MSG,
    PH_IPAD,
    PH_OPAD,
    PH_SEED,
    PH_INNER,
    PH_OUTER
  } phase_e;

  typedef enum logic [1:0] {
    CS_NONE,
    CS_IV,
    CS_IPAD,
    CS_OPAD
  } chain_src_e;

  typedef enum logic [3:0] {
    SV_NONE,
    SV_KEY,
    SV_IPAD,
    SV_OPAD,
    SV_SEED,
    SV_DIGEST,
    SV_STATE,
    SV_T1,
    SV_T2
  } save_e;

  typedef struct packed {
    chain_src_e  chain_src;
    logic        load;
    logic [6:0]  pos;
    phase_e      phase;
    logic        use_salt;
    logic        comp_init;
    logic        round;
    logic [6:0]  rnd;
    logic        comp_fin;
    save_e       save;
    logic        emit;
    logic [3:0]  word;
  } dp_cmd_t;

  typedef struct packed {
    logic two_blocks;
  } dp_stat_t;

endpackage

FILE: rtl/pbe_sha1_hmac_key_derive_top.sv
// ----------------------------------------------------------------------------
// pbe_sha1_hmac_key_derive_top
// Password key derivation: sha-1 key hash, then three hmac-sha1 passes,
// emitting a 40-byte key as ten 32-bit big-endian words.
// ----------------------------------------------------------------------------
// usage
//   command channel: an item is taken when start is high and busy is low.
//   func 0 / 1 write one byte into the message / salt store (no result;
//   salt writes past index 31 are dropped). func 2 derives.
//   func 3 does nothing.
//   config channel: cfg_index_i 0 sets message_length, 1 sets salt_length;
//   cfg_ready_o is always high. write only while busy is low.
//   results: ten beats on key_valid_o, one per cycle, words 0..9, the
//   last flagged by last_word_o. the receiver cannot stall them.
//   work: each sha-1 block takes 64 byte loads from the single store read
//   port, 80 rounds of one shared round unit and four control steps; a
//   derive runs nine blocks plus a salt seed load, and one more key
//   block when message_length is 56 or more.
//   one item at a time: busy stays high until the last word has shown.
//   reset: lengths go to 20 and 16, control goes idle; stores keep
//   whatever they hold until written.
module pbe_sha1_hmac_key_derive_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [5:0]  byte_index_i,
  input  logic [7:0]  byte_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output logic        key_valid_o,
  output logic [31:0] key_word_o,
  output logic [3:0]  word_number_o,
  output logic        last_word_o
);

  logic [6:0] msg_len_q;
  logic [5:0] salt_len_q;
  logic       ctrl_busy;
  logic       take;

  pbe_pkg::dp_cmd_t  cmd;
  pbe_pkg::dp_stat_t stat;

  logic [pbe_pkg::MsgAw-1:0]  msg_raddr;
  logic [pbe_pkg::SaltAw-1:0] salt_raddr;
  logic [7:0]                 msg_rdata, salt_rdata;

  assign busy        = ctrl_busy | key_valid_o;
  assign take        = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q  <= 7'd20;
      salt_len_q <= 6'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pbe_pkg::CFG_MSG_LEN:  msg_len_q  <= cfg_data_i;
        pbe_pkg::CFG_SALT_LEN: salt_len_q <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  pbe_ram #(.Width(8), .Depth(pbe_pkg::MsgDepth)) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (take && func_i == pbe_pkg::FN_MSG),
    .waddr_i (byte_index_i),
    .wdata_i (byte_value_i),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  pbe_ram #(.Width(8), .Depth(pbe_pkg::SaltDepth)) u_salt_ram (
    .clk_i   (clk_i),
    .we_i    (take && func_i == pbe_pkg::FN_SALT && !byte_index_i[5]),
    .waddr_i (byte_index_i[4:0]),
    .wdata_i (byte_value_i),
    .raddr_i (salt_raddr),
    .rdata_o (salt_rdata)
  );

  pbe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (take),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  pbe_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .msg_len_i     (msg_len_q),
    .salt_len_i    (salt_len_q),
    .msg_raddr_o   (msg_raddr),
    .msg_rdata_i   (msg_rdata),
    .salt_raddr_o  (salt_raddr),
    .salt_rdata_i  (salt_rdata),
    .key_valid_o   (key_valid_o),
    .key_word_o    (key_word_o),
    .word_number_o (word_number_o),
    .last_word_o   (last_word_o)
  );

endmodule

FILE: rtl/pbe_ram.sv
// ----------------------------------------------------------------------------
// pbe_ram
// Generic simple dual-port ram: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/pbe_dp.sv
// ----------------------------------------------------------------------------
// pbe_dp
// Datapath: block builder with sha-1 padding, iterative sha-1 round unit,
// chaining/context registers and the key word output register.
// ----------------------------------------------------------------------------
module pbe_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbe_pkg::dp_cmd_t            cmd_i,
  output pbe_pkg::dp_stat_t           stat_o,
  input  logic [6:0]                  msg_len_i,
  input  logic [5:0]                  salt_len_i,
  output logic [pbe_pkg::MsgAw-1:0]   msg_raddr_o,
  input  logic [7:0]                  msg_rdata_i,
  output logic [pbe_pkg::SaltAw-1:0]  salt_raddr_o,
  input  logic [7:0]                  salt_rdata_i,
  output logic                        key_valid_o,
  output logic [31:0]                 key_word_o,
  output logic [3:0]                  word_number_o,
  output logic                        last_word_o
);

  function automatic logic [7:0] pick_byte(input logic [159:0] v, input logic [4:0] i);
    logic [159:0] sh;
    sh = v << {i, 3'b000};
    return sh[159:152];
  endfunction

  function automatic logic [31:0] pick_word(input logic [159:0] v, input logic [2:0] i);
    logic [159:0] sh;
    sh = v << {i, 5'b00000};
    return sh[159:128];
  endfunction

  logic [6:0]   mlen;
  logic [5:0]   slen;
  logic [4:0]   stlen;
  logic         ld_q;
  logic [6:0]   pos_q;
  logic [511:0] blk_q;
  logic [159:0] cur_q, key_q, ipc_q, opc_q, st_q, dig_q, t1_q, t2_q;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic         valid_q;
  logic [31:0]  word_q;
  logic [3:0]   num_q;
  logic         last_q;

  // saturate lengths to store depth
  assign mlen  = (msg_len_i > 7'd64) ? 7'd64 : msg_len_i;
  assign slen  = (salt_len_i > 6'd32) ? 6'd32 : salt_len_i;
  assign stlen = (slen > 6'd20) ? 5'd20 : slen[4:0];

  assign stat_o.two_blocks = (mlen >= 7'd56);

  assign msg_raddr_o  = cmd_i.pos[5:0];
  assign salt_raddr_o = (cmd_i.phase == pbe_pkg::PH_INNER) ? 5'(cmd_i.pos - 7'd20)
                                                           : cmd_i.pos[4:0];

  // byte that enters the block in this beat
  logic [6:0] dlen, total;
  logic [9:0] bits;
  logic       padded, last_blk;
  logic [7:0] dat, nbyte;

  always_comb begin
    dlen   = 7'd0;
    total  = 7'd0;
    padded = 1'b0;
    dat    = 8'd0;
    unique case (cmd_i.phase)
      pbe_pkg::PH_MSG: begin
        dlen   = mlen;
        total  = mlen;
        padded = 1'b1;
        dat    = msg_rdata_i;
      end
      pbe_pkg::PH_IPAD: begin
        dat = ((pos_q < 7'd20) ? pick_byte(key_q, pos_q[4:0]) : 8'd0) ^ pbe_pkg::IpadByte;
      end
      pbe_pkg::PH_OPAD: begin
        dat = ((pos_q < 7'd20) ? pick_byte(key_q, pos_q[4:0]) : 8'd0) ^ pbe_pkg::OpadByte;
      end
      pbe_pkg::PH_SEED: begin
        dat = (pos_q < {2'b00, stlen}) ? salt_rdata_i : 8'd0;
      end
      pbe_pkg::PH_INNER: begin
        dlen   = 7'd20 + (cmd_i.use_salt ? {1'b0, slen} : 7'd0);
        total  = dlen + 7'd64;
        padded = 1'b1;
        dat    = (pos_q < 7'd20) ? pick_byte(st_q, pos_q[4:0]) : salt_rdata_i;
      end
      pbe_pkg::PH_OUTER: begin
        dlen   = 7'd20;
        total  = 7'd84;
        padded = 1'b1;
        dat    = pick_byte(dig_q, pos_q[4:0]);
      end
      default: begin
        dat = 8'd0;
      end
    endcase
    bits     = {total, 3'b000};
    last_blk = (cmd_i.phase == pbe_pkg::PH_MSG && stat_o.two_blocks) ? pos_q[6] : 1'b1;
    priority if (!padded) begin
      nbyte = dat;
    end else if (pos_q < dlen) begin
      nbyte = dat;
    end else if (pos_q == dlen) begin
      nbyte = pbe_pkg::PadByte;
    end else if (last_blk && pos_q[5:0] == 6'd62) begin
      nbyte = {6'b000000, bits[9:8]};
    end else if (last_blk && pos_q[5:0] == 6'd63) begin
      nbyte = bits[7:0];
    end else begin
      nbyte = 8'd0;
    end
  end

  // sha-1 round logic
  logic [31:0] w0, wnew_x, wnew, f, k, tmp;

  assign w0     = blk_q[511:480];
  assign wnew_x = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ w0;
  assign wnew   = {wnew_x[30:0], wnew_x[31]};

  always_comb begin
    priority if (cmd_i.rnd < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5a827999;
    end else if (cmd_i.rnd < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ed9eba1;
    end else if (cmd_i.rnd < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8f1bbcdc;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hca62c1d6;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      ld_q    <= cmd_i.load;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= cmd_i.pos;
    if (ld_q) begin
      blk_q <= {blk_q[503:0], nbyte};
    end else if (cmd_i.round) begin
      blk_q <= {blk_q[479:0], wnew};
    end
    if (cmd_i.comp_init) begin
      {a_q, b_q, c_q, d_q, e_q} <= cur_q;
    end else if (cmd_i.round) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= tmp;
    end
    if (cmd_i.comp_fin) begin
      cur_q <= {cur_q[159:128] + a_q, cur_q[127:96] + b_q, cur_q[95:64] + c_q,
                cur_q[63:32] + d_q, cur_q[31:0] + e_q};
    end else begin
      unique case (cmd_i.chain_src)
        pbe_pkg::CS_IV:   cur_q <= pbe_pkg::Sha1Iv;
        pbe_pkg::CS_IPAD: cur_q <= ipc_q;
        pbe_pkg::CS_OPAD: cur_q <= opc_q;
        default:          cur_q <= cur_q;
      endcase
    end
    unique case (cmd_i.save)
      pbe_pkg::SV_KEY:    key_q <= cur_q;
      pbe_pkg::SV_IPAD:   ipc_q <= cur_q;
      pbe_pkg::SV_OPAD:   opc_q <= cur_q;
      pbe_pkg::SV_SEED:   st_q  <= blk_q[159:0];
      pbe_pkg::SV_DIGEST: dig_q <= cur_q;
      pbe_pkg::SV_STATE:  st_q  <= cur_q;
      pbe_pkg::SV_T1:     t1_q  <= cur_q;
      pbe_pkg::SV_T2:     t2_q  <= cur_q;
      default: begin
      end
    endcase
    if (cmd_i.emit) begin
      word_q <= (cmd_i.word < 4'd5) ? pick_word(t1_q, cmd_i.word[2:0])
                                    : pick_word(t2_q, 3'(cmd_i.word - 4'd5));
      num_q  <= cmd_i.word;
      last_q <= (cmd_i.word == 4'(pbe_pkg::KeyWords - 1));
    end
  end

  assign key_valid_o   = valid_q;
  assign key_word_o    = word_q;
  assign word_number_o = num_q;
  assign last_word_o   = last_q;

endmodule

FILE: rtl/pbe_ctrl.sv
// ----------------------------------------------------------------------------
// pbe_ctrl
// Controller: walks the derive job list (key hash, pad contexts, seed,
// three hmacs) and drives the datapath through load, round and save steps.
// ----------------------------------------------------------------------------
module pbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        func_i,
  input  pbe_pkg::dp_stat_t stat_i,
  output pbe_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_LOAD, ST_LWAIT, ST_ROUND, ST_FIN, ST_SAVE, ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    JB_KEY, JB_IPAD, JB_OPAD, JB_SEED, JB_IN1, JB_OUT1, JB_IN2, JB_OUT2, JB_IN3, JB_OUT3
  } job_e;

  state_e     state_q;
  job_e       job_q;
  logic [6:0] pos_q;
  logic [6:0] rnd_q;
  logic [3:0] word_q;

  pbe_pkg::phase_e     phase;
  pbe_pkg::chain_src_e src;
  pbe_pkg::save_e      sv;
  logic                use_salt;

  always_comb begin
    phase    = pbe_pkg::PH_MSG;
    src      = pbe_pkg::CS_IV;
    sv       = pbe_pkg::SV_KEY;
    use_salt = 1'b1;
    unique case (job_q)
      JB_KEY:  begin phase = pbe_pkg::PH_MSG;   src = pbe_pkg::CS_IV;   sv = pbe_pkg::SV_KEY;    end
      JB_IPAD: begin phase = pbe_pkg::PH_IPAD;  src = pbe_pkg::CS_IV;   sv = pbe_pkg::SV_IPAD;   end
      JB_OPAD: begin phase = pbe_pkg::PH_OPAD;  src = pbe_pkg::CS_IV;   sv = pbe_pkg::SV_OPAD;   end
      JB_SEED: begin phase = pbe_pkg::PH_SEED;  src = pbe_pkg::CS_NONE; sv = pbe_pkg::SV_SEED;   end
      JB_IN1:  begin phase = pbe_pkg::PH_INNER; src = pbe_pkg::CS_IPAD; sv = pbe_pkg::SV_DIGEST; end
      JB_OUT1: begin phase = pbe_pkg::PH_OUTER; src = pbe_pkg::CS_OPAD; sv = pbe_pkg::SV_T1;     end
      JB_IN2: begin
        phase    = pbe_pkg::PH_INNER;
        src      = pbe_pkg::CS_IPAD;
        sv       = pbe_pkg::SV_DIGEST;
        use_salt = 1'b0;
      end
      JB_OUT2: begin phase = pbe_pkg::PH_OUTER; src = pbe_pkg::CS_OPAD; sv = pbe_pkg::SV_STATE;  end
      JB_IN3:  begin phase = pbe_pkg::PH_INNER; src = pbe_pkg::CS_IPAD; sv = pbe_pkg::SV_DIGEST; end
      JB_OUT3: begin phase = pbe_pkg::PH_OUTER; src = pbe_pkg::CS_OPAD; sv = pbe_pkg::SV_T2;     end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.chain_src = (state_q == ST_INIT) ? src : pbe_pkg::CS_NONE;
    cmd_o.load      = (state_q == ST_LOAD);
    cmd_o.pos       = pos_q;
    cmd_o.phase     = phase;
    cmd_o.use_salt  = use_salt;
    cmd_o.comp_init = (state_q == ST_LWAIT) && (job_q != JB_SEED);
    cmd_o.round     = (state_q == ST_ROUND);
    cmd_o.rnd       = rnd_q;
    cmd_o.comp_fin  = (state_q == ST_FIN);
    cmd_o.save      = (state_q == ST_SAVE) ? sv : pbe_pkg::SV_NONE;
    cmd_o.emit      = (state_q == ST_EMIT);
    cmd_o.word      = word_q;
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JB_KEY;
      pos_q   <= '0;
      rnd_q   <= '0;
      word_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i && func_i == pbe_pkg::FN_DERIVE) begin
            job_q   <= JB_KEY;
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          pos_q   <= '0;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          pos_q <= pos_q + 7'd1;
          if ((job_q == JB_SEED) ? (pos_q == 7'(pbe_pkg::DigestBytes - 1))
                                 : (pos_q[5:0] == 6'd63)) begin
            state_q <= ST_LWAIT;
          end
        end
        ST_LWAIT: begin
          rnd_q   <= '0;
          state_q <= (job_q == JB_SEED) ? ST_SAVE : ST_ROUND;
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'(pbe_pkg::Rounds - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          // long key message spills into a second block
          if (job_q == JB_KEY && stat_i.two_blocks && pos_q == 7'd64) begin
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_SAVE;
          end
        end
        ST_SAVE: begin
          if (job_q == JB_OUT3) begin
            word_q  <= '0;
            state_q <= ST_EMIT;
          end else begin
            job_q   <= job_e'(job_q + 4'd1);
            state_q <= ST_INIT;
          end
        end
        ST_EMIT: begin
          word_q <= word_q + 4'd1;
          if (word_q == 4'(pbe_pkg::KeyWords - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/pbe_chk.sv
// ----------------------------------------------------------------------------
// pbe_chk
// Port-level checks on the key derive block, bound to the top level.
// ----------------------------------------------------------------------------
module pbe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func_i,
  input logic        key_valid_o,
  input logic [3:0]  word_number_o,
  input logic        last_word_o
);

  // result beats only while a derive is in flight
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o |-> busy) else $error("key beat while not busy");

  // words come back to back in order
  a_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o && !last_word_o |=>
      key_valid_o && word_number_o == 4'($past(word_number_o) + 4'd1))
    else $error("key words not consecutive");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o |-> (last_word_o == (word_number_o == 4'd9)))
    else $error("last flag on wrong word");

  a_derive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i == pbe_pkg::FN_DERIVE |=> busy)
    else $error("derive not started");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i != pbe_pkg::FN_DERIVE |=> !key_valid_o && !busy)
    else $error("byte write caused activity");

endmodule

bind pbe_sha1_hmac_key_derive_top pbe_chk u_pbe_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .func_i        (func_i),
  .key_valid_o   (key_valid_o),
  .word_number_o (word_number_o),
  .last_word_o   (last_word_o)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sha-1 / hmac-sha1 key derivation block. It
// loads both byte stores, derives keys under several length settings and
// compares each of the ten key words with a local sha-1 / hmac model.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [31:0] word;
    logic [3:0]  num;
    logic        last;
  } key_beat_t;

  class key_scoreboard;
    logic [7:0] msg_mem[pbe_pkg::MsgDepth];
    logic [7:0] salt_mem[pbe_pkg::SaltDepth];
    logic [6:0] msg_len;
    logic [5:0] salt_len;
    key_beat_t  key_words_q[$];
    int         errors;

    function new();
      msg_len = 7'd20;
      salt_len = 6'd16;
      errors = 0;
    endfunction

    function void set_reg(pbe_pkg::cfg_idx_e idx, logic [6:0] data);
      if (idx == pbe_pkg::CFG_MSG_LEN) msg_len = data;
      else salt_len = data[5:0];
    endfunction

    function logic [159:0] compress(logic [159:0] h, logic [511:0] blk);
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      int i;
      for (i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
      for (i = 16; i < 80; i++) begin
        t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {t[30:0], t[31]};
      end
      {a, b, c, d, e} = h;
      for (i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5a827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ed9eba1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
        end else begin
          f = b ^ c ^ d; k = 32'hca62c1d6;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    // finish a hash whose first pre_len bytes are already folded into h
    function logic [159:0] sha_tail(logic [159:0] h, int pre_len, byte_q_t q);
      logic [63:0]  bits;
      logic [511:0] blk;
      int i, j;
      bits = 64'(pre_len + q.size()) * 8;
      q.push_back(pbe_pkg::PadByte);
      while (q.size() % 64 != 56) q.push_back(8'h00);
      for (i = 0; i < 8; i++) q.push_back(bits[63-8*i -: 8]);
      for (i = 0; i < q.size(); i += 64) begin
        for (j = 0; j < 64; j++) blk[511-8*j -: 8] = q[i+j];
        h = compress(h, blk);
      end
      return h;
    endfunction

    function logic [159:0] hmac(logic [159:0] ci, logic [159:0] co,
                                logic [159:0] st, int n_salt);
      byte_q_t q;
      logic [159:0] inner;
      int i;
      for (i = 0; i < 20; i++) q.push_back(st[159-8*i -: 8]);
      for (i = 0; i < n_salt; i++) q.push_back(salt_mem[i]);
      inner = sha_tail(ci, 64, q);
      q.delete();
      for (i = 0; i < 20; i++) q.push_back(inner[159-8*i -: 8]);
      return sha_tail(co, 64, q);
    endfunction

    function void derive_key();
      byte_q_t q;
      logic [159:0] key, ci, co, st, t1, t2;
      logic [511:0] iblk, oblk;
      logic [7:0] kb;
      key_beat_t beat;
      int mlen, slen, i;
      mlen = (msg_len > pbe_pkg::MsgDepth) ? pbe_pkg::MsgDepth : msg_len;
      slen = (salt_len > pbe_pkg::SaltDepth) ? pbe_pkg::SaltDepth : salt_len;
      for (i = 0; i < mlen; i++) q.push_back(msg_mem[i]);
      key = sha_tail(pbe_pkg::Sha1Iv, 0, q);
      for (i = 0; i < 64; i++) begin
        kb = (i < 20) ? key[159-8*i -: 8] : 8'h00;
        iblk[511-8*i -: 8] = kb ^ pbe_pkg::IpadByte;
        oblk[511-8*i -: 8] = kb ^ pbe_pkg::OpadByte;
      end
      ci = compress(pbe_pkg::Sha1Iv, iblk);
      co = compress(pbe_pkg::Sha1Iv, oblk);
      st = '0;
      for (i = 0; i < slen && i < 20; i++) st[159-8*i -: 8] = salt_mem[i];
      t1 = hmac(ci, co, st, slen);
      st = hmac(ci, co, st, 0);
      t2 = hmac(ci, co, st, slen);
      for (i = 0; i < pbe_pkg::KeyWords; i++) begin
        beat.word = (i < 5) ? t1[159-32*i -: 32] : t2[159-32*(i-5) -: 32];
        beat.num = 4'(i);
        beat.last = (i == pbe_pkg::KeyWords - 1);
        key_words_q.push_back(beat);
      end
    endfunction

    function void note_item(pbe_pkg::func_e fn, logic [5:0] idx, logic [7:0] val);
      case (fn)
        pbe_pkg::FN_MSG: msg_mem[idx] = val;
        pbe_pkg::FN_SALT: if (idx < pbe_pkg::SaltDepth) salt_mem[idx[4:0]] = val;
        pbe_pkg::FN_DERIVE: derive_key();
        default: ;
      endcase
    endfunction

    function void check_word(logic [31:0] word, logic [3:0] num, logic last);
      key_beat_t exp_beat;
      if (key_words_q.size() == 0) begin
        $display("%0t: unexpected key beat, got %h/%0d/%0b", $time, word, num, last);
        errors++;
        return;
      end
      exp_beat = key_words_q.pop_front();
      if (word !== exp_beat.word) begin
        $display("%0t: key_word exp %h got %h", $time, exp_beat.word, word);
        errors++;
      end
      if (num !== exp_beat.num) begin
        $display("%0t: word_number exp %0d got %0d", $time, exp_beat.num, num);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last_word exp %0b got %0b", $time, exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = '0;
  logic [5:0]  byte_index_i = '0;
  logic [7:0]  byte_value_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;
  logic        key_valid_o;
  logic [31:0] key_word_o;
  logic [3:0]  word_number_o;
  logic        last_word_o;

  key_scoreboard sb = new();
  int burst_left = 0;

  pbe_sha1_hmac_key_derive_top dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && key_valid_o) sb.check_word(key_word_o, word_number_o, last_word_o);
  end

  task automatic send_item(pbe_pkg::func_e fn, logic [5:0] idx, logic [7:0] val);
    int gap;
    start <= 1'b1;
    func_i <= fn;
    byte_index_i <= idx;
    byte_value_i <= val;
    do @(posedge clk_i); while (busy);
    sb.note_item(fn, idx, val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // pause the sender until every key word has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.key_words_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(pbe_pkg::cfg_idx_e idx, logic [6:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) send_item(pbe_pkg::FN_DERIVE, 6'($urandom), 8'($urandom));
    else if (r < 18) send_item(pbe_pkg::FN_NONE, 6'($urandom), 8'($urandom));
    else if (r < 60) send_item(pbe_pkg::FN_MSG, 6'($urandom), 8'($urandom));
    else send_item(pbe_pkg::FN_SALT, 6'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [6:0] msg_set[8];
    logic [5:0] salt_set[8];
    int p, n;
    msg_set = '{7'd20, 7'd0, 7'd127, 7'd64, 7'd55, 7'd56, 7'd19, 7'd40};
    salt_set = '{6'd16, 6'd0, 6'd63, 6'd32, 6'd20, 6'd21, 6'd1, 6'd31};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill both stores so no derive reads an unwritten byte
    for (n = 0; n < pbe_pkg::MsgDepth; n++) send_item(pbe_pkg::FN_MSG, 6'(n), 8'($urandom));
    for (n = 0; n < pbe_pkg::SaltDepth; n++) send_item(pbe_pkg::FN_SALT, 6'(n), 8'($urandom));

    // directed: reset lengths, field extremes, ignored writes, unused code
    send_item(pbe_pkg::FN_DERIVE, 6'd0, 8'd0);
    send_item(pbe_pkg::FN_MSG, 6'd0, 8'h00);
    send_item(pbe_pkg::FN_MSG, 6'd63, 8'hff);
    send_item(pbe_pkg::FN_SALT, 6'd0, 8'hff);
    send_item(pbe_pkg::FN_SALT, 6'd31, 8'h00);
    send_item(pbe_pkg::FN_SALT, 6'd32, 8'h5a);
    send_item(pbe_pkg::FN_SALT, 6'd63, 8'hff);
    send_item(pbe_pkg::FN_NONE, 6'd63, 8'hff);
    send_item(pbe_pkg::FN_DERIVE, 6'd63, 8'hff);

    for (p = 0; p < 8; p++) begin
      if (p == 7) begin
        msg_set[p] = 7'($urandom_range(0, 127));
        salt_set[p] = 6'($urandom_range(0, 63));
      end
      write_reg(pbe_pkg::CFG_MSG_LEN, msg_set[p]);
      write_reg(pbe_pkg::CFG_SALT_LEN, {1'b0, salt_set[p]});
      send_item(pbe_pkg::FN_DERIVE, 6'($urandom), 8'($urandom));
      for (n = 0; n < 20; n++) random_item();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("[pbe_sha1_hmac_key_derive_top] OK");
    else $display("[pbe_sha1_hmac_key_derive_top] ERROR");
    $finish;
  end

  initial begin
    #(20 * 2000000);
    $display("[pbe_sha1_hmac_key_derive_top] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pbe_pkg.sv
rtl/pbe_ram.sv
rtl/pbe_dp.sv
rtl/pbe_ctrl.sv
rtl/pbe_sha1_hmac_key_derive_top.sv
rtl/pbe_chk.sv
test/tb_top.sv
